@@ rtl/ffe_pkg.sv @@
// Package for the FORCE flux pipeline: word types, pipeline schedule, register
// indexes and saturating fixed-point helpers.
// No dependencies.
`default_nettype none

package ffe_pkg;

   localparam int WORD_BITS = 64;
   localparam int FRAC_BITS = 32;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [WORD_BITS-1:0]        mag_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam word_type ONE_Q    =
      {{(WORD_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

   // pipeline schedule, in cycles after the operands are presented
   localparam int DIV_LAT  = WORD_BITS + 2;
   localparam int MUL_LAT  = 3;
   localparam int FX_K     = DIV_LAT + MUL_LAT;
   localparam int FX_T     = FX_K + 2;
   localparam int FX_P     = FX_T + MUL_LAT;
   localparam int FX_E     = FX_P + 1;
   localparam int FLUX_LAT = FX_E + MUL_LAT;

   // configuration registers
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 34;
   localparam int DT_BITS       = 33;
   localparam int DX_BITS       = 33;
   localparam int GAMMA_BITS    = 34;

   localparam logic [CSR_IDX_BITS-1:0] CSR_TIME_STEP  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CELL_WIDTH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEAT_RATIO = 2'd2;

   localparam logic [DT_BITS-1:0]    DT_RESET    = 33'd4294967;
   localparam logic [DX_BITS-1:0]    DX_RESET    = 33'd42949673;
   localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = 34'd6012954214;

   function automatic mag_type mag_of(word_type x);
      return x[WORD_BITS-1] ? mag_type'(-x) : mag_type'(x);
   endfunction

   function automatic word_type from_sm(logic neg, mag_type m);
      word_type r;
      if (neg) begin
         if (m > mag_type'(WORD_MIN)) r = WORD_MIN;
         else r = -word_type'(m);
      end else begin
         r = m[WORD_BITS-1] ? WORD_MAX : word_type'(m);
      end
      return r;
   endfunction

   function automatic word_type sat_add(word_type a, word_type b);
      logic [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
      return word_type'(s[WORD_BITS-1:0]);
   endfunction

   function automatic word_type sat_sub(word_type a, word_type b);
      logic [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
      return word_type'(s[WORD_BITS-1:0]);
   endfunction

   // product with one half, rounded half away from zero
   function automatic word_type half_of(word_type x);
      mag_type m;
      m = mag_type'(mag_of(x) + mag_type'(1));
      return from_sm(x[WORD_BITS-1], m >> 1);
   endfunction

   function automatic logic is_pos(word_type x);
      return !x[WORD_BITS-1] && (x != '0);
   endfunction

endpackage

`default_nettype wire

@@ rtl/ffe_mul.sv @@
// Pipelined saturating fixed-point multiplier, rounded to nearest.
// Depends on ffe_pkg.
`default_nettype none

module ffe_mul (
   input  wire              clock,
   input  wire ffe_pkg::word_type a,
   input  wire ffe_pkg::word_type b,
   output ffe_pkg::word_type p
);
   import ffe_pkg::*;

   localparam int H = WORD_BITS / 2;

   mag_type              ma_ff, mb_ff;
   logic                 neg1_ff, neg2_ff;
   logic [WORD_BITS-1:0] pp_ff [4];
   word_type             p_ff;

   logic [2*WORD_BITS-1:0] prod_in;
   logic [2*WORD_BITS-1:0] rnd_in;

   always_comb begin
      prod_in = {pp_ff[3], pp_ff[0]}
              + {{H{1'b0}}, pp_ff[1], {H{1'b0}}}
              + {{H{1'b0}}, pp_ff[2], {H{1'b0}}};
      rnd_in  = prod_in + ((2*WORD_BITS)'(1) << (FRAC_BITS - 1));
   end

   always_ff @(posedge clock) begin
      ma_ff    <= mag_of(a);
      mb_ff    <= mag_of(b);
      neg1_ff  <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
      // four half-width partial products
      pp_ff[0] <= ma_ff[H-1:0] * mb_ff[H-1:0];
      pp_ff[1] <= ma_ff[H-1:0] * mb_ff[WORD_BITS-1:H];
      pp_ff[2] <= ma_ff[WORD_BITS-1:H] * mb_ff[H-1:0];
      pp_ff[3] <= ma_ff[WORD_BITS-1:H] * mb_ff[WORD_BITS-1:H];
      neg2_ff  <= neg1_ff;
      if (rnd_in[2*WORD_BITS-1:WORD_BITS+FRAC_BITS] != '0) begin
         p_ff <= neg2_ff ? WORD_MIN : WORD_MAX;
      end else begin
         p_ff <= from_sm(neg2_ff, rnd_in[WORD_BITS+FRAC_BITS-1:FRAC_BITS]);
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

@@ rtl/ffe_div.sv @@
// Pipelined saturating fixed-point divider, one quotient bit per stage.
// Depends on ffe_pkg.
`default_nettype none

module ffe_div (
   input  wire              clock,
   input  wire ffe_pkg::word_type num,
   input  wire ffe_pkg::word_type den,
   output ffe_pkg::word_type quo
);
   import ffe_pkg::*;

   localparam int STEPS = WORD_BITS;

   mag_type  rem_ff [STEPS+1], rem_in [STEPS+1];
   mag_type  lq_ff [STEPS+1], lq_in [STEPS+1];    // dividend bits out, quotient bits in
   mag_type  den_ff [STEPS+1], den_in [STEPS+1];
   logic     neg_ff [STEPS+1], neg_in [STEPS+1];
   logic     spec_ff [STEPS+1], spec_in [STEPS+1];
   word_type specv_ff [STEPS+1], specv_in [STEPS+1];
   word_type quo_ff;

   always_comb begin
      mag_type            ma, mb;
      logic [WORD_BITS:0] trial;
      logic               take;
      ma = mag_of(num);
      mb = mag_of(den);
      rem_in[0]  = ma >> (WORD_BITS - FRAC_BITS);
      lq_in[0]   = ma << FRAC_BITS;
      den_in[0]  = mb;
      neg_in[0]  = num[WORD_BITS-1] ^ den[WORD_BITS-1];
      spec_in[0] = 1'b1;
      if (ma == '0) begin
         specv_in[0] = '0;
      end else if (mb == '0) begin
         specv_in[0] = num[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
      end else if ((ma >> (WORD_BITS - FRAC_BITS)) >= mb) begin
         specv_in[0] = neg_in[0] ? WORD_MIN : WORD_MAX;
      end else begin
         spec_in[0]  = 1'b0;
         specv_in[0] = '0;
      end
      for (int j = 0; j < STEPS; j++) begin
         trial = {rem_ff[j], lq_ff[j][WORD_BITS-1]};
         take  = trial >= {1'b0, den_ff[j]};
         rem_in[j+1]   = take ? mag_type'(trial - {1'b0, den_ff[j]})
                              : trial[WORD_BITS-1:0];
         lq_in[j+1]    = {lq_ff[j][WORD_BITS-2:0], take};
         den_in[j+1]   = den_ff[j];
         neg_in[j+1]   = neg_ff[j];
         spec_in[j+1]  = spec_ff[j];
         specv_in[j+1] = specv_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= STEPS; j++) begin
         rem_ff[j]   <= rem_in[j];
         lq_ff[j]    <= lq_in[j];
         den_ff[j]   <= den_in[j];
         neg_ff[j]   <= neg_in[j];
         spec_ff[j]  <= spec_in[j];
         specv_ff[j] <= specv_in[j];
      end
      quo_ff <= spec_ff[STEPS] ? specv_ff[STEPS] : from_sm(neg_ff[STEPS], lq_ff[STEPS]);
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

@@ rtl/ffe_flux.sv @@
// Pipelined ideal-gas physical flux of one conservative state.
// Depends on ffe_pkg, ffe_div and ffe_mul.
`default_nettype none

module ffe_flux (
   input  wire              clock,
   input  wire ffe_pkg::word_type u0,
   input  wire ffe_pkg::word_type u1,
   input  wire ffe_pkg::word_type u2,
   input  wire ffe_pkg::word_type g1,
   output ffe_pkg::word_type f0,
   output ffe_pkg::word_type f1,
   output ffe_pkg::word_type f2
);
   import ffe_pkg::*;

   localparam int K_DLY  = FX_P - FX_K;
   localparam int V_DLY  = FX_E - DIV_LAT;
   localparam int F1_DLY = FLUX_LAT - FX_E + 1;

   word_type u1_d_ff [FLUX_LAT];
   word_type u2_d_ff [FX_P];
   word_type k_d_ff [K_DLY];
   word_type v_d_ff [V_DLY];
   word_type f1_d_ff [F1_DLY];
   word_type hk_ff, t_ff, es_ff;
   word_type vel, kin, prs, f2_w;

   ffe_div u_vel (.clock(clock), .num(u1), .den(u0), .quo(vel));
   ffe_mul u_kin (.clock(clock), .a(u1_d_ff[DIV_LAT-1]), .b(vel), .p(kin));
   ffe_mul u_prs (.clock(clock), .a(g1), .b(t_ff), .p(prs));
   ffe_mul u_enf (.clock(clock), .a(es_ff), .b(v_d_ff[V_DLY-1]), .p(f2_w));

   always_ff @(posedge clock) begin
      u1_d_ff[0] <= u1;
      for (int i = 1; i < FLUX_LAT; i++) u1_d_ff[i] <= u1_d_ff[i-1];
      u2_d_ff[0] <= u2;
      for (int i = 1; i < FX_P; i++) u2_d_ff[i] <= u2_d_ff[i-1];
      k_d_ff[0] <= kin;
      for (int i = 1; i < K_DLY; i++) k_d_ff[i] <= k_d_ff[i-1];
      v_d_ff[0] <= vel;
      for (int i = 1; i < V_DLY; i++) v_d_ff[i] <= v_d_ff[i-1];
      // E - k/2, then pressure, then k + p and E + p
      hk_ff <= half_of(kin);
      t_ff  <= sat_sub(u2_d_ff[FX_K], hk_ff);
      f1_d_ff[0] <= sat_add(k_d_ff[K_DLY-1], prs);
      for (int i = 1; i < F1_DLY; i++) f1_d_ff[i] <= f1_d_ff[i-1];
      es_ff <= sat_add(u2_d_ff[FX_P-1], prs);
   end

   assign f0 = u1_d_ff[FLUX_LAT-1];
   assign f1 = f1_d_ff[F1_DLY-1];
   assign f2 = f2_w;

endmodule

`default_nettype wire

@@ rtl/force_flux_euler_1d_top.sv @@
// FORCE flux for the 1-D Euler equations: top level with request, response
// and register ports. Depends on ffe_pkg, ffe_div, ffe_mul and ffe_flux.
//
// Usage:
//  - Request: drive the six conservative inputs (left/right density, momentum,
//    energy, signed Q32.32) and raise start. A request is taken on every
//    clock edge where start is high and busy is low; busy stays low, so one
//    interface state pair can be issued every cycle.
//  - Response: rsp_strobe is high for exactly one cycle, with the mass,
//    momentum and energy flux and bad_density. Responses come back in
//    request order. The receiver cannot stall; the pipeline never waits.
//  - Latency is set by two passes through the physical flux unit, most of
//    it the 64-stage velocity divider that retires one quotient bit per
//    stage, plus the Lax-Friedrichs/Richtmyer combine.
//  - Registers: csr_write_enable, csr_index, csr_write_data write time_step
//    (0), cell_width (1) and heat_ratio (2); other indexes are dropped. Write
//    them only with no request in flight. dx/dt and dt/dx come from two
//    free-running divider pipelines fed from the registers; they settle after a write.
//  - Reset (synchronous, active high) restores the register defaults and
//    drops every request in flight.
`default_nettype none

module force_flux_euler_1d_top (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     start,
   output logic                                    busy,
   input  wire ffe_pkg::word_type                  req_left_density,
   input  wire ffe_pkg::word_type                  req_left_momentum,
   input  wire ffe_pkg::word_type                  req_left_energy,
   input  wire ffe_pkg::word_type                  req_right_density,
   input  wire ffe_pkg::word_type                  req_right_momentum,
   input  wire ffe_pkg::word_type                  req_right_energy,
   input  wire                                     csr_write_enable,
   input  wire [ffe_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  wire [ffe_pkg::CSR_DATA_BITS-1:0]        csr_write_data,
   output logic                                    rsp_strobe,
   output ffe_pkg::word_type                       rsp_mass_flux,
   output ffe_pkg::word_type                       rsp_momentum_flux,
   output ffe_pkg::word_type                       rsp_energy_flux,
   output logic                                    rsp_bad_density
);
   import ffe_pkg::*;

   // schedule, in cycles after the request edge
   localparam int G_AT   = FLUX_LAT + 1;     // flux sums and differences
   localparam int H_AT   = G_AT + MUL_LAT;   // scaled by dt/dx and dx/dt
   localparam int I_AT   = H_AT + 1;         // halves
   localparam int J_AT   = I_AT + 1;         // Richtmyer state and LxF flux
   localparam int K_AT   = J_AT + FLUX_LAT + 1;
   localparam int RSP_AT = K_AT + 1;

   logic                  accept;
   logic [DT_BITS-1:0]    dt_ff;
   logic [DX_BITS-1:0]    dx_ff;
   logic [GAMMA_BITS-1:0] gamma_ff;
   word_type              g1_ff;
   word_type              dt_w, dx_w, lxf_coef, rich_coef;

   word_type ul_ff [3], ur_ff [3];
   word_type ul_d_ff [FLUX_LAT][3], ur_d_ff [FLUX_LAT][3];
   word_type fl_w [3], fr_w [3], fs_w [3];
   word_type df_ff [3], sf_ff [3], du_ff [3], su_ff [3];
   word_type sf_d_ff [MUL_LAT][3], su_d_ff [MUL_LAT][3];
   word_type ra_w [3], lb_w [3];
   word_type ha_ff [3], hb_ff [3], hsu_ff [3], hsf_ff [3];
   word_type s_ff [3], lax_ff [3];
   word_type lax_d_ff [FLUX_LAT][3];
   word_type sum_ff [3];
   logic     vld_ff [K_AT+1];
   logic     bad_ff [K_AT+1];

   logic     strobe_ff, bad_out_ff;
   word_type flux_ff [3];

   // every cycle is open for a request
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff    <= DT_RESET;
         dx_ff    <= DX_RESET;
         gamma_ff <= GAMMA_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TIME_STEP:  dt_ff    <= csr_write_data[DT_BITS-1:0];
            CSR_CELL_WIDTH: dx_ff    <= csr_write_data[DX_BITS-1:0];
            CSR_HEAT_RATIO: gamma_ff <= csr_write_data[GAMMA_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign dt_w = word_type'(dt_ff);
   assign dx_w = word_type'(dx_ff);

   // gamma - 1 and the two mesh ratios track the registers continuously
   always_ff @(posedge clock) begin
      g1_ff <= sat_sub(word_type'(gamma_ff), ONE_Q);
   end

   ffe_div u_lxf_coef  (.clock(clock), .num(dx_w), .den(dt_w), .quo(lxf_coef));
   ffe_div u_rich_coef (.clock(clock), .num(dt_w), .den(dx_w), .quo(rich_coef));

   // capture the request; the valid line marks which slots are live
   always_ff @(posedge clock) begin
      ul_ff[0] <= req_left_density;
      ul_ff[1] <= req_left_momentum;
      ul_ff[2] <= req_left_energy;
      ur_ff[0] <= req_right_density;
      ur_ff[1] <= req_right_momentum;
      ur_ff[2] <= req_right_energy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= K_AT; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
         for (int i = 1; i <= K_AT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // bad-density flag: set by the inputs, then by the Richtmyer density
   always_ff @(posedge clock) begin
      bad_ff[0] <= !(is_pos(req_left_density) && is_pos(req_right_density));
      for (int i = 1; i <= K_AT; i++) begin
         if (i == J_AT + 1) bad_ff[i] <= bad_ff[i-1] || !is_pos(s_ff[0]);
         else bad_ff[i] <= bad_ff[i-1];
      end
   end

   // physical fluxes of the left and right states
   ffe_flux u_flux_l (
      .clock(clock), .u0(ul_ff[0]), .u1(ul_ff[1]), .u2(ul_ff[2]), .g1(g1_ff),
      .f0(fl_w[0]), .f1(fl_w[1]), .f2(fl_w[2])
   );
   ffe_flux u_flux_r (
      .clock(clock), .u0(ur_ff[0]), .u1(ur_ff[1]), .u2(ur_ff[2]), .g1(g1_ff),
      .f0(fr_w[0]), .f1(fr_w[1]), .f2(fr_w[2])
   );

   // hold the states until their fluxes are out
   always_ff @(posedge clock) begin
      ul_d_ff[0] <= ul_ff;
      ur_d_ff[0] <= ur_ff;
      for (int i = 1; i < FLUX_LAT; i++) begin
         ul_d_ff[i] <= ul_d_ff[i-1];
         ur_d_ff[i] <= ur_d_ff[i-1];
      end
   end

   // sums and differences of states and fluxes
   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         df_ff[c] <= sat_sub(fr_w[c], fl_w[c]);
         sf_ff[c] <= sat_add(fr_w[c], fl_w[c]);
         du_ff[c] <= sat_sub(ul_d_ff[FLUX_LAT-1][c], ur_d_ff[FLUX_LAT-1][c]);
         su_ff[c] <= sat_add(ul_d_ff[FLUX_LAT-1][c], ur_d_ff[FLUX_LAT-1][c]);
      end
   end

   // scale by the mesh ratios
   for (genvar c = 0; c < 3; c++) begin : g_scale
      ffe_mul u_rich (.clock(clock), .a(rich_coef), .b(df_ff[c]), .p(ra_w[c]));
      ffe_mul u_lxf  (.clock(clock), .a(lxf_coef),  .b(du_ff[c]), .p(lb_w[c]));
   end

   always_ff @(posedge clock) begin
      sf_d_ff[0] <= sf_ff;
      su_d_ff[0] <= su_ff;
      for (int i = 1; i < MUL_LAT; i++) begin
         sf_d_ff[i] <= sf_d_ff[i-1];
         su_d_ff[i] <= su_d_ff[i-1];
      end
      for (int c = 0; c < 3; c++) begin
         ha_ff[c]  <= half_of(ra_w[c]);
         hb_ff[c]  <= half_of(lb_w[c]);
         hsu_ff[c] <= half_of(su_d_ff[MUL_LAT-1][c]);
         hsf_ff[c] <= half_of(sf_d_ff[MUL_LAT-1][c]);
         // Richtmyer intermediate state and Lax-Friedrichs flux
         s_ff[c]   <= sat_sub(hsu_ff[c], ha_ff[c]);
         lax_ff[c] <= sat_add(hb_ff[c], hsf_ff[c]);
      end
   end

   // physical flux of the Richtmyer state
   ffe_flux u_flux_s (
      .clock(clock), .u0(s_ff[0]), .u1(s_ff[1]), .u2(s_ff[2]), .g1(g1_ff),
      .f0(fs_w[0]), .f1(fs_w[1]), .f2(fs_w[2])
   );

   // hold the Lax-Friedrichs flux, average, drop flux on a bad density
   always_ff @(posedge clock) begin
      lax_d_ff[0] <= lax_ff;
      for (int i = 1; i < FLUX_LAT; i++) lax_d_ff[i] <= lax_d_ff[i-1];
      for (int c = 0; c < 3; c++) begin
         sum_ff[c]  <= sat_add(lax_d_ff[FLUX_LAT-1][c], fs_w[c]);
         flux_ff[c] <= bad_ff[K_AT] ? '0 : half_of(sum_ff[c]);
      end
      bad_out_ff <= bad_ff[K_AT];
   end

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else strobe_ff <= vld_ff[K_AT];
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_mass_flux     = flux_ff[0];
   assign rsp_momentum_flux = flux_ff[1];
   assign rsp_energy_flux   = flux_ff[2];
   assign rsp_bad_density   = bad_out_ff;

   // every request gets its response after the fixed latency
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(RSP_AT + 1) rsp_strobe)
      else $error("request without response");

   // no response without a matching request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, RSP_AT + 1))
      else $error("response without request");

   // a non-positive input density is flagged
   a_bad_input: assert property (@(posedge clock) disable iff (reset)
      accept && (req_left_density <= 0 || req_right_density <= 0)
      |-> ##(RSP_AT + 1) rsp_bad_density)
      else $error("bad input density not flagged");

   // flagged responses carry zero flux
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_bad_density
      |-> rsp_mass_flux == 0 && rsp_momentum_flux == 0 && rsp_energy_flux == 0)
      else $error("flagged response with nonzero flux");

endmodule

`default_nettype wire

@@ test/force_flux_euler_1d_top_test.sv @@
// Self-checking testbench for force_flux_euler_1d_top: drives interface state pairs
// through several register settings and checks every flux against its own predictor or a typed value.
// Depends on ffe_pkg and the RTL of force_flux_euler_1d_top.
`default_nettype none

module force_flux_euler_1d_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ffe_pkg::*;

   // index past the last register; the block must drop writes to it
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int N_PHASES  = 6;
   localparam int PHASE_LEN = 205;
   localparam int SETTLE    = 100;

   typedef struct {
      word_type ld, lm, le, rd, rm, re;
   } cell_pair_type;

   typedef struct {
      word_type mass, mom, energy;
      logic     bad;
   } flux_type;

   typedef struct {
      cell_pair_type st;
      bit            typed;   // expected value written in the row
      flux_type      res;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   word_type          req_left_density = '0, req_left_momentum = '0, req_left_energy = '0;
   word_type          req_right_density = '0, req_right_momentum = '0, req_right_energy = '0;
   logic              csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;
   logic              rsp_strobe;
   word_type          rsp_mass_flux, rsp_momentum_flux, rsp_energy_flux;
   logic              rsp_bad_density;

   // predictor copy of the registers
   logic [DT_BITS-1:0]    dt_reg  = DT_RESET;
   logic [DX_BITS-1:0]    dx_reg  = DX_RESET;
   logic [GAMMA_BITS-1:0] gam_reg = GAMMA_RESET;

   flux_type pending_flux[$];
   int       fails = 0;
   bit       no_idle = 1'b0;

   force_flux_euler_1d_top u_top (
      .clock, .reset, .start, .busy,
      .req_left_density, .req_left_momentum, .req_left_energy,
      .req_right_density, .req_right_momentum, .req_right_energy,
      .csr_write_enable, .csr_index, .csr_write_data,
      .rsp_strobe, .rsp_mass_flux, .rsp_momentum_flux, .rsp_energy_flux,
      .rsp_bad_density
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------- fixed-point predictor ----------------

   function automatic mag_type abs_mag(word_type x);
      return x[WORD_BITS-1] ? mag_type'(~x) + mag_type'(1) : mag_type'(x);
   endfunction

   // signed value from sign and magnitude, clamped to the word
   function automatic word_type signed_word(logic neg, mag_type m);
      if (neg) begin
         if (m == '0) return '0;
         if (m > mag_type'(WORD_MIN)) return WORD_MIN;
         return word_type'(~m + mag_type'(1));
      end
      return m[WORD_BITS-1] ? WORD_MAX : word_type'(m);
   endfunction

   function automatic word_type q_add(word_type a, word_type b);
      logic signed [WORD_BITS:0] s;
      s = (WORD_BITS+1)'(a) + (WORD_BITS+1)'(b);
      if (s > WORD_MAX) return WORD_MAX;
      if (s < WORD_MIN) return WORD_MIN;
      return s[WORD_BITS-1:0];
   endfunction

   function automatic word_type q_sub(word_type a, word_type b);
      logic signed [WORD_BITS:0] s;
      s = (WORD_BITS+1)'(a) - (WORD_BITS+1)'(b);
      if (s > WORD_MAX) return WORD_MAX;
      if (s < WORD_MIN) return WORD_MIN;
      return s[WORD_BITS-1:0];
   endfunction

   // product, rounded to nearest with ties away from zero
   function automatic word_type q_mul(word_type a, word_type b);
      logic       neg;
      logic [127:0] p;
      neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
      p = {64'd0, abs_mag(a)} * {64'd0, abs_mag(b)} + (128'd1 << (FRAC_BITS - 1));
      if (p[127:96] != '0) return neg ? WORD_MIN : WORD_MAX;
      return signed_word(neg, p[95:32]);
   endfunction

   // quotient truncated toward zero
   function automatic word_type q_div(word_type a, word_type b);
      logic       neg;
      mag_type    ma, mb;
      logic [127:0] q;
      neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
      ma = abs_mag(a);
      mb = abs_mag(b);
      if (ma == '0) return '0;
      if (mb == '0) return a[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
      if ((ma >> FRAC_BITS) >= mb) return neg ? WORD_MIN : WORD_MAX;
      q = ({64'd0, ma} << FRAC_BITS) / {64'd0, mb};
      return signed_word(neg, q[63:0]);
   endfunction

   function automatic word_type half(word_type x);
      return q_mul(word_type'(1) <<< (FRAC_BITS - 1), x);
   endfunction

   // ideal-gas Euler flux of (density, momentum, energy)
   function automatic void euler_flux(input word_type u[3], input word_type g1,
                                      output word_type f[3]);
      word_type v, k, p;
      v = q_div(u[1], u[0]);
      k = q_mul(u[1], v);
      p = q_mul(g1, q_sub(u[2], half(k)));
      f[0] = u[1];
      f[1] = q_add(k, p);
      f[2] = q_mul(q_add(u[2], p), v);
   endfunction

   function automatic flux_type predict_flux(cell_pair_type c);
      word_type ul[3], ur[3], fl[3], fr[3], s[3], fs[3], lxf;
      word_type dt, dx, g1, lf, ri;
      flux_type r;
      dt = word_type'(dt_reg);
      dx = word_type'(dx_reg);
      g1 = q_sub(word_type'(gam_reg), ONE_Q);
      ul = '{c.ld, c.lm, c.le};
      ur = '{c.rd, c.rm, c.re};
      r = '{'0, '0, '0, 1'b1};
      if (ul[0] <= 0 || ur[0] <= 0) return r;
      lf = q_div(dx, dt);
      ri = q_div(dt, dx);
      euler_flux(ul, g1, fl);
      euler_flux(ur, g1, fr);
      for (int i = 0; i < 3; i++)
         s[i] = q_sub(half(q_add(ul[i], ur[i])), half(q_mul(ri, q_sub(fr[i], fl[i]))));
      if (s[0] <= 0) return r;
      euler_flux(s, g1, fs);
      for (int i = 0; i < 3; i++) begin
         lxf = q_add(half(q_mul(lf, q_sub(ul[i], ur[i]))), half(q_add(fr[i], fl[i])));
         fs[i] = half(q_add(lxf, fs[i]));
      end
      r = '{fs[0], fs[1], fs[2], 1'b0};
      return r;
   endfunction

   // ---------------- stimulus ----------------

   function automatic word_type qv(int signed ipart, bit [31:0] fpart);
      return (word_type'(ipart) <<< FRAC_BITS) + word_type'({32'd0, fpart});
   endfunction

   function automatic word_type rand_word();
      return {$urandom(), $urandom()};
   endfunction

   function automatic cell_pair_type rand_cell_pair();
      cell_pair_type c;
      int unsigned mode, span;
      mode = $urandom_range(0, 19);
      if (mode == 0) begin
         // raw noise: every bit of every field toggles
         c = '{rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
               rand_word()};
         return c;
      end
      span = (mode == 1) ? 100000 : 15;
      c.ld = qv($urandom_range(0, span), $urandom()) + word_type'(1);
      c.rd = qv($urandom_range(0, span), $urandom()) + word_type'(1);
      c.lm = qv(int'($urandom_range(0, 2 * span + 10)) - int'(span) - 5, $urandom());
      c.rm = qv(int'($urandom_range(0, 2 * span + 10)) - int'(span) - 5, $urandom());
      c.le = qv($urandom_range(0, 20 * span), $urandom());
      c.re = qv($urandom_range(0, 20 * span), $urandom());
      // broken sequences: a non-positive density on one side
      if (mode == 2) c.ld = -word_type'($urandom_range(0, 3));
      if (mode == 3) c.rd = WORD_MIN + word_type'($urandom());
      return c;
   endfunction

   // hold the request until the block takes it, then log the expected flux
   task automatic send_request(cell_pair_type c, bit typed, flux_type typed_res);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start              <= 1'b1;
      req_left_density   <= c.ld;
      req_left_momentum  <= c.lm;
      req_left_energy    <= c.le;
      req_right_density  <= c.rd;
      req_right_momentum <= c.rm;
      req_right_energy   <= c.re;
      do @(posedge clock); while (busy);
      pending_flux.push_back(typed ? typed_res : predict_flux(c));
   endtask

   // drop start and wait for every outstanding flux
   task automatic drain();
      start <= 1'b0;
      while (pending_flux.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      case (idx)
         CSR_TIME_STEP:  dt_reg  = val[DT_BITS-1:0];
         CSR_CELL_WIDTH: dx_reg  = val[DX_BITS-1:0];
         CSR_HEAT_RATIO: gam_reg = val[GAMMA_BITS-1:0];
         default: ;
      endcase
   endtask

   // register settings per phase: dt, dx, gamma (phase 0 keeps the reset values)
   task automatic set_phase_regs(int ph);
      logic [CSR_DATA_BITS-1:0] one_q, dt_v, dx_v, g_v;
      one_q = 34'd1 << FRAC_BITS;
      case (ph)
         1: begin dt_v = 34'd1;  dx_v = 34'd1;  g_v = one_q + 34'd1; end
         2: begin dt_v = one_q;  dx_v = one_q;  g_v = 34'd3 * one_q; end
         3: begin dt_v = 34'd1;  dx_v = one_q;  g_v = 34'd6871947674; end
         4: begin dt_v = one_q;  dx_v = 34'd1;  g_v = 34'd7158278827; end
         default: begin
            dt_v = CSR_DATA_BITS'($urandom_range(1, 42949673));
            dx_v = CSR_DATA_BITS'($urandom_range(42949673, 429496730));
            g_v  = one_q + CSR_DATA_BITS'($urandom_range(1, 32'hFFFF_FFFF));
         end
      endcase
      write_reg(CSR_TIME_STEP, dt_v);
      write_reg(CSR_CELL_WIDTH, dx_v);
      write_reg(CSR_HEAT_RATIO, g_v);
      // out-of-range index: predictor ignores it too
      write_reg(CSR_UNUSED, {CSR_DATA_BITS{1'b1}});
      csr_write_enable <= 1'b0;
   endtask

   // ---------------- response checker ----------------

   always @(posedge clock) begin
      flux_type e;
      if (!reset && rsp_strobe) begin
         if (pending_flux.size() == 0) begin
            $display("%0t: unexpected flux response", $time);
            fails++;
         end else begin
            e = pending_flux.pop_front();
            if (rsp_mass_flux !== e.mass) begin
               $display("%0t: mass_flux exp %0d got %0d", $time, e.mass, rsp_mass_flux);
               fails++;
            end
            if (rsp_momentum_flux !== e.mom) begin
               $display("%0t: momentum_flux exp %0d got %0d", $time, e.mom,
                        rsp_momentum_flux);
               fails++;
            end
            if (rsp_energy_flux !== e.energy) begin
               $display("%0t: energy_flux exp %0d got %0d", $time, e.energy,
                        rsp_energy_flux);
               fails++;
            end
            if (rsp_bad_density !== e.bad) begin
               $display("%0t: bad_density exp %0b got %0b", $time, e.bad, rsp_bad_density);
               fails++;
            end
         end
      end
   end

   // ---------------- main sequence ----------------

   initial begin
      stim_row_type  rows[$];
      flux_type      bad_res, none;
      cell_pair_type c;
      bad_res = '{'0, '0, '0, 1'b1};
      none    = '{'0, '0, '0, 1'b0};

      // directed table; typed expectations only for rejected densities
      rows.push_back('{'{'0, qv(1, 0), qv(3, 0), qv(1, 0), '0, qv(2, 0)}, 1, bad_res});
      rows.push_back('{'{qv(1, 0), '0, qv(2, 0), '0, qv(1, 0), qv(3, 0)}, 1, bad_res});
      rows.push_back('{'{-qv(1, 0), '0, qv(2, 0), qv(1, 0), '0, qv(2, 0)}, 1, bad_res});
      rows.push_back('{'{qv(1, 0), '0, qv(2, 0), WORD_MIN, '0, qv(2, 0)}, 1, bad_res});
      rows.push_back('{'{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN},
                       1, bad_res});
      rows.push_back('{'{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX},
                       0, none});
      rows.push_back('{'{WORD_MAX, WORD_MIN, '0, WORD_MAX, WORD_MAX, WORD_MIN}, 0, none});
      rows.push_back('{'{1, 1, 1, 1, -1, 1}, 0, none});
      // uniform flow, Sod shock tube, strong expansion (intermediate density < 0 at the reset mesh ratios)
      rows.push_back('{'{qv(1, 0), qv(1, 0), qv(3, 0), qv(1, 0), qv(1, 0), qv(3, 0)},
                       0, none});
      rows.push_back('{'{qv(1, 0), '0, qv(2, 32'h8000_0000), qv(0, 32'h2000_0000), '0,
                         qv(0, 32'h4000_0000)}, 0, none});
      rows.push_back('{'{qv(1, 0), -qv(100, 0), qv(50, 0), qv(1, 0), qv(100, 0), qv(50, 0)},
                       0, none});
      rows.push_back('{'{qv(2, 0), qv(-7, 0), '0, qv(3, 0), qv(5, 0), -qv(4, 0)}, 0, none});
      rows.push_back('{'{1, WORD_MAX, WORD_MAX, 1, WORD_MIN, WORD_MIN}, 0, none});

      // hold reset once, at the start
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // let the rate dividers settle on the reset values
      repeat (SETTLE) @(posedge clock);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         if (ph != 0) begin
            // registers change only with the pipeline empty
            drain();
            set_phase_regs(ph);
            repeat (SETTLE) @(posedge clock);
         end
         no_idle = (ph % 2) == 1;
         foreach (rows[i]) send_request(rows[i].st, rows[i].typed, rows[i].res);
         for (int n = 0; n < PHASE_LEN; n++) begin
            // alternate stretches of back-to-back requests and random gaps
            if (n % 50 == 0) no_idle = $urandom_range(0, 2) == 0;
            c = rand_cell_pair();
            send_request(c, 0, none);
         end
         rows.delete();
      end

      drain();
      repeat (200) @(posedge clock);
      if (fails == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
